/* rtl/lzw_pkg.sv */
// Shared types and constants for the LZW encoder.
package lzw_pkg;

    localparam int BYTE_W    = 8;
    localparam int EPOCH_W   = 8;
    localparam int LIT_COUNT = 256;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_CHECK,
        ST_EMIT,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic start_byte;
        logic start_probe;
        logic step_probe;
        logic hit;
        logic write_entry;
        logic load_miss;
        logic load_final;
        logic clear_write;
        logic clear_done;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic started;
        logic eos;
        logic rd_valid;
        logic rd_match;
        logic dict_full;
        logic cnt_last;
        logic epoch_max;
        logic out_free;
    } sts_t;

endpackage

/* rtl/lzw_in_if.sv */
// Byte input channel with valid/ready handshake.
interface lzw_in_if;
    logic                       valid;
    logic                       ready;
    logic [lzw_pkg::BYTE_W-1:0] data_byte;
    logic                       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

/* rtl/lzw_out_if.sv */
// Code output channel with valid/ready handshake.
interface lzw_out_if #(
    parameter int CODE_WIDTH = 12
);
    logic                  valid;
    logic                  ready;
    logic [CODE_WIDTH-1:0] code;
    logic                  final_code;

    modport source (output valid, output code, output final_code, input ready);
    modport sink (input valid, input code, input final_code, output ready);
endinterface

/* rtl/lzw_ctrl.sv */
// Control state machine that sequences the dictionary sweep, dictionary probes and code output.
module lzw_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  lzw_pkg::sts_t sts,
    output lzw_pkg::cmd_t cmd
);
    import lzw_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_write = 1'b1;
                if (sts.cnt_last)
                begin
                    cmd.clear_done = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.in_valid)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (!sts.started)
                begin
                    cmd.start_byte = 1'b1;
                    state_next     = sts.eos ? ST_FINAL : ST_IDLE;
                end
                else
                begin
                    cmd.start_probe = 1'b1;
                    state_next      = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (sts.rd_valid && sts.rd_match)
                begin
                    cmd.hit    = 1'b1;
                    state_next = sts.eos ? ST_FINAL : ST_IDLE;
                end
                else if (!sts.rd_valid)
                begin
                    cmd.write_entry = !sts.dict_full;
                    state_next      = ST_EMIT;
                end
                else if (sts.cnt_last)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.step_probe = 1'b1;
                    state_next     = ST_READ;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_miss = 1'b1;
                    state_next    = sts.eos ? ST_FINAL : ST_IDLE;
                end
            end
            ST_FINAL:
            begin
                if (sts.out_free)
                begin
                    cmd.load_final = 1'b1;
                    state_next     = sts.epoch_max ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/lzw_datapath.sv */
// Dictionary memory, string and code registers, and the output register.
module lzw_datapath #(
    parameter int CODE_WIDTH    = 12,
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    lzw_in_if.sink        in_ch,
    lzw_out_if.source     out_ch,
    input  lzw_pkg::cmd_t cmd,
    output lzw_pkg::sts_t sts
);
    import lzw_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int HW = (CODE_WIDTH > IW) ? CODE_WIDTH : IW;

    logic [EPOCH_W-1:0]    mem_tag    [TABLE_ENTRIES];
    logic [CODE_WIDTH-1:0] mem_prefix [TABLE_ENTRIES];
    logic [BYTE_W-1:0]     mem_byte   [TABLE_ENTRIES];
    logic [CODE_WIDTH-1:0] mem_code   [TABLE_ENTRIES];

    logic [EPOCH_W-1:0]    rd_tag_reg;
    logic [CODE_WIDTH-1:0] rd_prefix_reg;
    logic [BYTE_W-1:0]     rd_byte_reg;
    logic [CODE_WIDTH-1:0] rd_code_reg;

    logic [BYTE_W-1:0]     byte_reg;
    logic                  eos_reg;
    logic                  started_reg;
    logic [CODE_WIDTH-1:0] cur_reg;
    logic [CODE_WIDTH:0]   next_free_reg;
    logic [IW-1:0]         idx_reg;
    logic [IW-1:0]         off_reg;
    logic [IW-1:0]         cnt_reg;
    logic [EPOCH_W-1:0]    epoch_reg;
    logic                  out_valid_reg;
    logic [CODE_WIDTH-1:0] out_code_reg;
    logic                  out_final_reg;

    logic [HW-1:0]         hash_full;
    logic [IW-1:0]         hash_idx;
    logic [IW-1:0]         hash_off;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [EPOCH_W-1:0]    wr_tag;
    logic                  in_accept;

    assign in_accept = in_ch.valid && cmd.in_ready;
    assign in_ch.ready = cmd.in_ready;

    assign hash_full = (HW'(byte_reg) << (CODE_WIDTH - BYTE_W)) ^ HW'(cur_reg);
    assign hash_idx  = hash_full[IW-1:0];
    assign hash_off  = (hash_idx == '0) ? IW'(1) : (~hash_idx + IW'(1));

    assign wr_en   = cmd.write_entry || cmd.clear_write;
    assign wr_addr = cmd.clear_write ? cnt_reg : idx_reg;
    assign wr_tag  = cmd.clear_write ? '0 : epoch_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_tag[wr_addr]    <= wr_tag;
            mem_prefix[wr_addr] <= cur_reg;
            mem_byte[wr_addr]   <= byte_reg;
            mem_code[wr_addr]   <= next_free_reg[CODE_WIDTH-1:0];
        end
        rd_tag_reg    <= mem_tag[idx_reg];
        rd_prefix_reg <= mem_prefix[idx_reg];
        rd_byte_reg   <= mem_byte[idx_reg];
        rd_code_reg   <= mem_code[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_reg <= in_ch.data_byte;
            eos_reg  <= in_ch.end_of_stream;
        end
        if (cmd.start_probe)
        begin
            idx_reg <= hash_idx;
            off_reg <= hash_off;
        end
        else if (cmd.step_probe)
        begin
            idx_reg <= idx_reg - off_reg;
        end
        if (cmd.load_miss || cmd.load_final)
        begin
            out_code_reg  <= cur_reg;
            out_final_reg <= cmd.load_final;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            cur_reg       <= '0;
            next_free_reg <= (CODE_WIDTH + 1)'(LIT_COUNT);
            cnt_reg       <= '0;
            epoch_reg     <= EPOCH_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start_byte)
            begin
                started_reg <= 1'b1;
                cur_reg     <= CODE_WIDTH'(byte_reg);
            end
            else if (cmd.hit)
            begin
                cur_reg <= rd_code_reg;
            end
            else if (cmd.load_miss)
            begin
                cur_reg <= CODE_WIDTH'(byte_reg);
            end
            else if (cmd.load_final)
            begin
                cur_reg     <= '0;
                started_reg <= 1'b0;
            end

            if (cmd.write_entry)
            begin
                next_free_reg <= next_free_reg + 1'b1;
            end
            else if (cmd.load_final)
            begin
                next_free_reg <= (CODE_WIDTH + 1)'(LIT_COUNT);
            end

            if (cmd.start_probe || cmd.load_final)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.step_probe || cmd.clear_write)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            if (cmd.clear_done)
            begin
                epoch_reg <= EPOCH_W'(1);
            end
            else if (cmd.load_final && !(&epoch_reg))
            begin
                epoch_reg <= epoch_reg + 1'b1;
            end

            if (cmd.load_miss || cmd.load_final)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.code       = out_code_reg;
    assign out_ch.final_code = out_final_reg;

    always_comb
    begin
        sts           = '0;
        sts.in_valid  = in_ch.valid;
        sts.started   = started_reg;
        sts.eos       = eos_reg;
        sts.rd_valid  = (rd_tag_reg == epoch_reg);
        sts.rd_match  = (rd_prefix_reg == cur_reg) && (rd_byte_reg == byte_reg);
        sts.dict_full = next_free_reg[CODE_WIDTH];
        sts.cnt_last  = &cnt_reg;
        sts.epoch_max = &epoch_reg;
        sts.out_free  = !out_valid_reg || out_ch.ready;
    end

    a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        epoch_reg != '0)
        else $error("Epoch mark reached zero, which matches cleared entries.");

    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg >= (CODE_WIDTH + 1)'(LIT_COUNT))
        else $error("Next free code fell below the literal range.");

    a_write_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_entry |-> !next_free_reg[CODE_WIDTH] && !cmd.clear_write)
        else $error("Dictionary entry written with no code left or during clearing.");

    a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_final |=> !started_reg
            && next_free_reg == (CODE_WIDTH + 1)'(LIT_COUNT) && out_final_reg)
        else $error("Stream state not restarted after the final code.");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_miss || cmd.load_final) |-> (!out_valid_reg || out_ch.ready))
        else $error("Output register overwritten before its transaction completed.");

endmodule

/* rtl/lzw_encoder_12bit.sv */
// Top level of the LZW encoder: byte stream in, dictionary codes out.
// The encoder takes one byte per input transaction and returns LZW codes on the output
// channel, with final_code set on the code that closes a stream (end_of_stream on its last
// byte). Bytes are taken one at a time. The dictionary sits in four arrays on one address
// with a registered read, so each probe passes a read state and a check state; a collision
// probe steps back to the read state, a miss adds an emit state, the first byte of a
// stream only opens the string, and end of stream adds a final state. A result waiting on
// the output does not block the next byte unless that byte needs the output register too.
// After reset the dictionary is swept clean before the first byte is taken; streams are
// retired with an 8-bit epoch mark, and after every 255th stream the same sweep runs again.
module lzw_encoder_12bit #(
    parameter int CODE_WIDTH    = 12,
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic      clk,
    input  logic      rst_n,
    lzw_in_if.sink    in_ch,
    lzw_out_if.source out_ch
);
    import lzw_pkg::*;

    cmd_t cmd;
    sts_t sts;

    lzw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    lzw_datapath #(
        .CODE_WIDTH    (CODE_WIDTH),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cmd    (cmd),
        .sts    (sts)
    );

endmodule

/* tb/sv/lzw_encoder_12bit_test.sv */
// Self-checking testbench for lzw_encoder_12bit: byte streams in, predicted LZW codes checked out.
module lzw_encoder_12bit_test;
    import lzw_pkg::*;

    localparam int CODE_W       = 12;
    localparam int TABLE_SIZE   = 4096;
    localparam int TOP_CODE     = (1 << CODE_W) - 1;
    localparam int IDLE_LIMIT   = 40000;
    localparam int HOLDOFF_LEN  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_BYTES = 600;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              final_code;
    } lzw_result_t;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SLOW,
        RX_PERIODIC
    } rx_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    lzw_in_if                        in_ch ();
    lzw_out_if #(.CODE_WIDTH(CODE_W)) out_ch ();

    lzw_encoder_12bit #(
        .CODE_WIDTH(CODE_W),
        .TABLE_ENTRIES(TABLE_SIZE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    bit                dict_used [TABLE_SIZE];
    logic [CODE_W-1:0] dict_code [TABLE_SIZE];
    logic [CODE_W-1:0] dict_prefix [TABLE_SIZE];
    logic [BYTE_W-1:0] dict_byte [TABLE_SIZE];
    logic [CODE_W-1:0] cur_string;
    int unsigned       next_code;
    bit                string_open;

    lzw_result_t expected_codes [$];
    int          error_count = 0;
    int          burst_left;
    int          holdoff_requests = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void encode_byte(input logic [BYTE_W-1:0] value, input logic last);
        int unsigned slot;
        int unsigned stride;
        bit          hit;
        bit          usable;
        lzw_result_t res;
        if (!string_open)
        begin
            cur_string  = CODE_W'(value);
            string_open = 1'b1;
        end
        else
        begin
            slot   = ((int'(value) << (CODE_W - BYTE_W)) ^ int'(cur_string)) % TABLE_SIZE;
            stride = (slot == 0) ? 1 : TABLE_SIZE - slot;
            hit    = 1'b0;
            usable = 1'b0;
            for (int n = 0; n < TABLE_SIZE; n++)
            begin
                if (!dict_used[slot])
                begin
                    usable = 1'b1;
                    break;
                end
                if (dict_prefix[slot] == cur_string && dict_byte[slot] == value)
                begin
                    hit    = 1'b1;
                    usable = 1'b1;
                    break;
                end
                slot = (slot + TABLE_SIZE - stride) % TABLE_SIZE;
            end
            if (hit)
            begin
                cur_string = dict_code[slot];
            end
            else
            begin
                if (usable && next_code <= TOP_CODE)
                begin
                    dict_used[slot]   = 1'b1;
                    dict_code[slot]   = CODE_W'(next_code);
                    dict_prefix[slot] = cur_string;
                    dict_byte[slot]   = value;
                    next_code++;
                end
                res.code       = cur_string;
                res.final_code = 1'b0;
                expected_codes.push_back(res);
                cur_string = CODE_W'(value);
            end
        end
        if (last)
        begin
            res.code       = cur_string;
            res.final_code = 1'b1;
            expected_codes.push_back(res);
            dict_used   = '{default: 1'b0};
            next_code   = LIT_COUNT;
            cur_string  = '0;
            string_open = 1'b0;
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_byte(input logic [BYTE_W-1:0] value, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= value;
        in_ch.end_of_stream <= last;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        encode_byte(value, last);
        @(negedge clk);
    endtask

    task automatic send_stream(input logic [BYTE_W-1:0] seq [$]);
        foreach (seq[i])
            send_byte(seq[i], i == seq.size() - 1);
    endtask

    // A symbol count of zero draws from the full byte range.
    task automatic send_random_stream(input int len, input int symbols);
        logic [BYTE_W-1:0] pool [4];
        foreach (pool[k])
            pool[k] = BYTE_W'($urandom_range(0, 255));
        for (int i = 0; i < len; i++)
        begin
            if (symbols == 0)
                send_byte(BYTE_W'($urandom_range(0, 255)), i == len - 1);
            else
                send_byte(pool[$urandom_range(0, symbols - 1)], i == len - 1);
        end
    endtask

    task automatic test_single_byte_streams();
        logic [BYTE_W-1:0] seq [$];
        seq = {8'h00};
        send_stream(seq);
        seq = {8'hFF};
        send_stream(seq);
    endtask

    task automatic test_repeated_byte();
        logic [BYTE_W-1:0] seq [$];
        seq = {8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41};
        send_stream(seq);
    endtask

    task automatic test_byte_extremes();
        logic [BYTE_W-1:0] seq [$];
        seq = {8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
        send_stream(seq);
    endtask

    // Pairs chosen to collide at hash index zero and at an even index, then hit again.
    task automatic test_hash_collisions();
        logic [BYTE_W-1:0] seq [$];
        seq = {8'h00, 8'h00, 8'h10, 8'h01, 8'h10, 8'h11,
               8'h00, 8'h00, 8'h10, 8'h01, 8'h10, 8'h11};
        send_stream(seq);
    endtask

    task automatic test_output_holdoff();
        holdoff_requests++;
        send_random_stream(40, 0);
    endtask

    task automatic test_epoch_sweep();
        for (int s = 0; s < 260; s++)
            send_random_stream($urandom_range(1, 2), 0);
    endtask

    task automatic test_random_streams();
        int sent;
        int kind;
        int len;
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 11)
            begin
                len = $urandom_range(2, 60);
                send_random_stream(len, $urandom_range(2, 4));
            end
            else if (kind < 15)
            begin
                len = $urandom_range(1, 30);
                send_random_stream(len, 0);
            end
            else if (kind < 19)
            begin
                len = $urandom_range(1, 3);
                send_random_stream(len, 0);
            end
            else
            begin
                len = $urandom_range(40, 120);
                send_random_stream(len, 1);
            end
            sent += len;
        end
    endtask

    initial
    begin : receiver
        rx_mode_t mode;
        int       mode_left;
        int       stall_left;
        int       phase;
        int       holdoff_seen;
        mode         = RX_ALWAYS;
        mode_left    = 0;
        stall_left   = 0;
        phase        = 0;
        holdoff_seen = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            phase++;
            if (holdoff_seen != holdoff_requests)
            begin
                holdoff_seen = holdoff_requests;
                stall_left   = HOLDOFF_LEN;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 200);
                end
                mode_left--;
                case (mode)
                    RX_ALWAYS:   out_ch.ready <= 1'b1;
                    RX_COIN:     out_ch.ready <= ($urandom_range(0, 1) == 1);
                    RX_SLOW:     out_ch.ready <= ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: out_ch.ready <= (phase % 3 == 0);
                    default:     out_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : check_codes
        lzw_result_t want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (expected_codes.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected code: expected none, actual code %0d final %0b",
                         $time, out_ch.code, out_ch.final_code);
            end
            else
            begin
                want = expected_codes.pop_front();
                if (out_ch.code !== want.code)
                begin
                    error_count++;
                    $display("%0t: code mismatch: expected %0d, actual %0d",
                             $time, want.code, out_ch.code);
                end
                if (out_ch.final_code !== want.final_code)
                begin
                    error_count++;
                    $display("%0t: final_code mismatch: expected %0b, actual %0b",
                             $time, want.final_code, out_ch.final_code);
                end
            end
        end
    end

    // Long probe chains and the dictionary sweep both stay well under the limit.
    always @(posedge clk)
    begin : watchdog
        int idle_cycles;
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("lzw_encoder_12bit_test: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.data_byte     = '0;
        in_ch.end_of_stream = 1'b0;
        burst_left          = 0;
        dict_used           = '{default: 1'b0};
        next_code           = LIT_COUNT;
        cur_string          = '0;
        string_open         = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_single_byte_streams();
        test_repeated_byte();
        test_byte_extremes();
        test_hash_collisions();
        test_output_holdoff();
        test_epoch_sweep();
        test_random_streams();

        in_ch.valid <= 1'b0;
        while (expected_codes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("lzw_encoder_12bit_test: PASS");
        else
            $display("lzw_encoder_12bit_test: FAIL");
        $finish;
    end

endmodule
